@@ rtl/ist_pkg.sv @@
`default_nettype none

package ist_pkg;

    // Field widths of the request and result beats.
    localparam int ACTION_W = 2;
    localparam int DEV_W    = 8;
    localparam int INO_W    = 16;
    localparam int IDX_W    = 6;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 8;

    // Request actions.
    localparam logic [ACTION_W-1:0] ACT_GET = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_DUP = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_PUT = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_HIT        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_CLAIMED    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DONE       = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL       = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_IN_USE = 3'd4;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW   = 3'd5;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

    // One slot of the table as it sits in the memory.
    typedef struct packed {
        logic [COUNT_W-1:0] refs;
        logic [DEV_W-1:0]   dev;
        logic [INO_W-1:0]   ino;
    } ist_entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_step;
        logic accept;
        logic scan_rd;
        logic named_rd;
        logic finish_scan;
        logic finish_named;
    } ist_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic data_vld;
        logic data_hit;
        logic data_last;
        logic issue_done;
        logic clear_last;
    } ist_stat_t;

endpackage

`default_nettype wire

@@ rtl/ist_ctrl.sv @@
`default_nettype none

module ist_ctrl (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [ist_pkg::ACTION_W-1:0]     action,
    input  ist_pkg::ist_stat_t               stat,
    output ist_pkg::ist_cmd_t                cmd,
    output logic                             busy
);
    import ist_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_NAMED_RD,
        S_NAMED_DO
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start && !busy_reg)
                begin
                    cmd.accept = 1'b1;
                    if (action == ACT_GET)
                    begin
                        state_next = S_SCAN;
                    end
                    else if (action == ACT_DUP || action == ACT_PUT)
                    begin
                        state_next = S_NAMED_RD;
                    end
                end
            end
            S_SCAN:
            begin
                if (stat.data_vld && (stat.data_hit || stat.data_last))
                begin
                    cmd.finish_scan = 1'b1;
                    state_next      = S_IDLE;
                end
                else
                begin
                    cmd.scan_rd = !stat.issue_done;
                end
            end
            S_NAMED_RD:
            begin
                cmd.named_rd = 1'b1;
                state_next   = S_NAMED_DO;
            end
            S_NAMED_DO:
            begin
                cmd.finish_named = 1'b1;
                state_next       = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            busy_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_IDLE);
        end
    end

    assign busy = busy_reg;

endmodule

`default_nettype wire

@@ rtl/ist_datapath.sv @@
`default_nettype none

module ist_datapath #(
    parameter int TABLE_SLOTS = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  ist_pkg::ist_cmd_t                cmd,
    output ist_pkg::ist_stat_t               stat,
    input  logic [ist_pkg::ACTION_W-1:0]     action,
    input  logic [ist_pkg::DEV_W-1:0]        device_number,
    input  logic [ist_pkg::INO_W-1:0]        inode_number,
    input  logic [ist_pkg::IDX_W-1:0]        slot_index,
    output logic                             done,
    output logic [ist_pkg::IDX_W-1:0]        result_slot,
    output logic [ist_pkg::STATUS_W-1:0]     status,
    output logic                             fresh_entry,
    output logic [ist_pkg::COUNT_W-1:0]      count_after
);
    import ist_pkg::*;

    localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CNT_W  = $clog2(TABLE_SLOTS + 1);

    ist_entry_t mem_ram [TABLE_SLOTS];

    // Request latched at accept.
    logic                req_put_reg;
    logic [DEV_W-1:0]    req_dev_reg;
    logic [INO_W-1:0]    req_ino_reg;
    logic [IDX_W-1:0]    req_idx_reg;

    // Scan and read pipeline.
    logic [CNT_W-1:0]    scan_addr_reg;
    logic [CNT_W-1:0]    scan_addr_next;
    logic [SLOT_W-1:0]   data_addr_reg;
    logic                data_vld_reg;
    ist_entry_t          rd_data_reg;
    logic                have_free_reg;
    logic                have_free_next;
    logic [SLOT_W-1:0]   free_slot_reg;
    logic [SLOT_W-1:0]   free_slot_next;

    // Memory ports.
    logic                rd_en;
    logic [SLOT_W-1:0]   rd_addr;
    logic                wr_en;
    logic [SLOT_W-1:0]   wr_addr;
    ist_entry_t          wr_data;

    // Result registers.
    logic                done_reg;
    logic                done_next;
    logic [IDX_W-1:0]    result_slot_reg;
    logic [IDX_W-1:0]    result_slot_next;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic                fresh_reg;
    logic                fresh_next;
    logic [COUNT_W-1:0]  count_reg;
    logic [COUNT_W-1:0]  count_next;

    logic [SLOT_W-1:0]   idx_addr;
    logic                idx_in_range;
    logic                data_free;
    logic                data_hit;

    assign idx_addr     = SLOT_W'(req_idx_reg);
    assign idx_in_range = (32'(req_idx_reg) < TABLE_SLOTS);
    assign data_free    = (rd_data_reg.refs == '0);
    assign data_hit     = data_vld_reg && !data_free &&
                          (rd_data_reg.dev == req_dev_reg) &&
                          (rd_data_reg.ino == req_ino_reg);

    assign stat.data_vld   = data_vld_reg;
    assign stat.data_hit   = data_hit;
    assign stat.data_last  = (data_addr_reg == SLOT_W'(TABLE_SLOTS - 1));
    assign stat.issue_done = (scan_addr_reg == CNT_W'(TABLE_SLOTS));
    assign stat.clear_last = (scan_addr_reg == CNT_W'(TABLE_SLOTS - 1));

    assign rd_en   = cmd.scan_rd || cmd.named_rd;
    assign rd_addr = cmd.named_rd ? idx_addr : scan_addr_reg[SLOT_W-1:0];

    always_comb
    begin
        scan_addr_next = scan_addr_reg;
        if (cmd.accept)
        begin
            scan_addr_next = '0;
        end
        else if (cmd.clear_step || cmd.scan_rd)
        begin
            scan_addr_next = scan_addr_reg + CNT_W'(1);
        end
    end

    always_comb
    begin
        have_free_next = have_free_reg;
        free_slot_next = free_slot_reg;
        if (cmd.accept)
        begin
            have_free_next = 1'b0;
        end
        else if (data_vld_reg && data_free && !have_free_reg)
        begin
            have_free_next = 1'b1;
            free_slot_next = data_addr_reg;
        end
    end

    always_comb
    begin
        wr_en            = 1'b0;
        wr_addr          = scan_addr_reg[SLOT_W-1:0];
        wr_data          = '0;
        done_next        = 1'b0;
        result_slot_next = result_slot_reg;
        status_next      = status_reg;
        fresh_next       = 1'b0;
        count_next       = count_reg;

        if (cmd.clear_step)
        begin
            wr_en = 1'b1;
        end

        if (cmd.finish_scan)
        begin
            done_next = 1'b1;
            if (data_hit)
            begin
                result_slot_next = IDX_W'(data_addr_reg);
                if (rd_data_reg.refs >= COUNT_MAX)
                begin
                    status_next = ST_OVERFLOW;
                    count_next  = rd_data_reg.refs;
                end
                else
                begin
                    wr_en        = 1'b1;
                    wr_addr      = data_addr_reg;
                    wr_data      = rd_data_reg;
                    wr_data.refs = rd_data_reg.refs + COUNT_W'(1);
                    status_next  = ST_HIT;
                    count_next   = wr_data.refs;
                end
            end
            else if (have_free_reg || data_free)
            begin
                wr_en            = 1'b1;
                wr_addr          = have_free_reg ? free_slot_reg : data_addr_reg;
                wr_data.refs     = COUNT_W'(1);
                wr_data.dev      = req_dev_reg;
                wr_data.ino      = req_ino_reg;
                result_slot_next = IDX_W'(wr_addr);
                status_next      = ST_CLAIMED;
                fresh_next       = 1'b1;
                count_next       = COUNT_W'(1);
            end
            else
            begin
                result_slot_next = '0;
                status_next      = ST_FULL;
                count_next       = '0;
            end
        end

        if (cmd.finish_named)
        begin
            done_next        = 1'b1;
            result_slot_next = req_idx_reg;
            if (!idx_in_range || data_free)
            begin
                status_next = ST_NOT_IN_USE;
                count_next  = '0;
            end
            else if (!req_put_reg && rd_data_reg.refs >= COUNT_MAX)
            begin
                status_next = ST_OVERFLOW;
                count_next  = rd_data_reg.refs;
            end
            else
            begin
                wr_en        = 1'b1;
                wr_addr      = idx_addr;
                wr_data      = rd_data_reg;
                wr_data.refs = req_put_reg ? rd_data_reg.refs - COUNT_W'(1)
                                           : rd_data_reg.refs + COUNT_W'(1);
                status_next  = ST_DONE;
                count_next   = wr_data.refs;
            end
        end
    end

    // Slot memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_ram[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_ram[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_put_reg <= (action == ACT_PUT);
            req_dev_reg <= device_number;
            req_ino_reg <= inode_number;
            req_idx_reg <= slot_index;
        end
        if (cmd.scan_rd)
        begin
            data_addr_reg <= scan_addr_reg[SLOT_W-1:0];
        end
        free_slot_reg   <= free_slot_next;
        result_slot_reg <= result_slot_next;
        status_reg      <= status_next;
        fresh_reg       <= fresh_next;
        count_reg       <= count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_addr_reg <= '0;
            data_vld_reg  <= 1'b0;
            have_free_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            scan_addr_reg <= scan_addr_next;
            data_vld_reg  <= cmd.scan_rd;
            have_free_reg <= have_free_next;
            done_reg      <= done_next;
        end
    end

    assign done        = done_reg;
    assign result_slot = result_slot_reg;
    assign status      = status_reg;
    assign fresh_entry = fresh_reg;
    assign count_after = count_reg;

    a_one_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.finish_scan, cmd.finish_named}))
        else $error("both finish commands asserted together");

    a_no_overread: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_rd |-> !stat.issue_done)
        else $error("scan read issued past the last slot");

    a_finish_done: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish_scan || cmd.finish_named) |=> done_reg)
        else $error("finished request produced no result beat");

    a_fresh_claim: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (fresh_reg == (status_reg == ST_CLAIMED)))
        else $error("fresh flag disagrees with status");

    a_hit_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (status_reg == ST_HIT || status_reg == ST_CLAIMED)) |->
        (count_reg != '0))
        else $error("hit or claim reported a zero count");

endmodule

`default_nettype wire

@@ rtl/refcounted_inode_slot_table.sv @@
`default_nettype none

// Channel   | Handshake                   | Payload
// ----------+-----------------------------+--------------------------------------------
// request   | start, busy (taken: start   | action, device_number, inode_number,
//           | high while busy low)        | slot_index
// result    | done (one-cycle strobe)     | result_slot, status, fresh_entry, count_after
//
// A get walks the table through one memory read port, one slot a cycle; it reads
// the whole table when it misses and stops early when a matching slot comes up.
// Dup and put read the named slot once in S_NAMED_RD and deliver their beat from the result registers after S_NAMED_DO.
// After reset a clearing pass zeroes every slot count, with busy high.
// Action code 3 is taken and dropped without a result beat.
// Results cannot be stalled: each beat shows on done for exactly one cycle.
module refcounted_inode_slot_table #(
    parameter int TABLE_SLOTS = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [ist_pkg::ACTION_W-1:0]     action,
    input  logic [ist_pkg::DEV_W-1:0]        device_number,
    input  logic [ist_pkg::INO_W-1:0]        inode_number,
    input  logic [ist_pkg::IDX_W-1:0]        slot_index,
    output logic                             done,
    output logic [ist_pkg::IDX_W-1:0]        result_slot,
    output logic [ist_pkg::STATUS_W-1:0]     status,
    output logic                             fresh_entry,
    output logic [ist_pkg::COUNT_W-1:0]      count_after
);
    import ist_pkg::*;

    // The controller sequences the clearing pass, the table walk and the
    // read-modify-write of a named slot; the datapath owns the slot memory,
    // the latched request, the first-free tracker and the result registers.
    ist_cmd_t  cmd;
    ist_stat_t stat;

    ist_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .stat   (stat),
        .cmd    (cmd),
        .busy   (busy)
    );

    ist_datapath #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .action        (action),
        .device_number (device_number),
        .inode_number  (inode_number),
        .slot_index    (slot_index),
        .done          (done),
        .result_slot   (result_slot),
        .status        (status),
        .fresh_entry   (fresh_entry),
        .count_after   (count_after)
    );

endmodule

`default_nettype wire
